// ----- hdl/dmbb_pkg.sv -----
package dmbb_pkg;

  localparam int COLUMNS   = 78;
  localparam int ROWS      = 16;
  localparam int MAX_CHARS = 200;

  localparam int COL_AW = $clog2(COLUMNS);
  localparam int ROW_IW = $clog2(ROWS);
  localparam int CUR_XW = $clog2(COLUMNS + 1);
  localparam int CUR_YW = $clog2(ROWS + 1);
  localparam int XC_W   = 8;
  localparam int YC_W   = 6;
  localparam int DOT_XW = 9;
  localparam int DOT_YW = 6;
  localparam int BYTE_W = 8;
  localparam int SPAN_W = 4;
  localparam int OFF_W  = 3;
  localparam int CNT_W  = 8;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 7;
  localparam int OUT_BITS_W = 16;

  typedef enum logic [CFG_IW-1:0] {
    REG_X_OFFSET = 3'd0,
    REG_Y_OFFSET = 3'd1,
    REG_COLOR    = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FN_CLEAR = 3'd0,
    FN_SET   = 3'd1,
    FN_START = 3'd2,
    FN_HEX   = 3'd3,
    FN_READ  = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RD_OUT,
    S_ALIGN,
    S_PIX,
    S_WRITE,
    S_ADV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } shift_ctrl_t;

  typedef struct packed {
    logic             bit_out;
    logic [OFF_W-1:0] offset;
    logic             last;
  } shift_stat_t;

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic letter;
    letter = (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    return letter ? c[3:0] + 4'd9 : c[3:0];
  endfunction

endpackage

// ----- hdl/dmbb_ram.sv -----
module dmbb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 78
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/dmbb_shift.sv -----
module dmbb_shift import dmbb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  shift_ctrl_t       ctrl,
  input  logic [BYTE_W-1:0] pix_byte,
  input  logic [SPAN_W-1:0] span,
  output shift_stat_t       stat
);

  logic [BYTE_W-1:0] sreg;
  logic [OFF_W-1:0]  off;
  logic [SPAN_W-1:0] left;

  // The leftmost pixel of the span is aligned to the top bit and leaves first.
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (ctrl.load) begin
      sreg <= pix_byte << (SPAN_W'(BYTE_W) - span);
      off  <= '0;
      left <= span;
    end else if (ctrl.step) begin
      sreg <= {sreg[BYTE_W-2:0], 1'b0};
      off  <= off + 1'b1;
      left <= left - 1'b1;
    end
  end

  assign stat.bit_out = sreg[BYTE_W-1];
  assign stat.offset  = off;
  assign stat.last    = (left <= SPAN_W'(1));

endmodule

// ----- hdl/dot_matrix_bitmap_blitter_unit.sv -----
// One-bit frame buffer for a 78 by 16 dot display, one 16-bit word per column, with
// commands to clear, set a dot, restart a bitmap, feed a hex character of a bitmap and
// read a column. Every accepted item gives exactly one result item. Clear, start
// bitmap, an invalid-size or over-limit hex character, the first digit of a pair and a
// set pixel or read column off the display go from the execute state straight to the result;
// set pixel and read column on the display first pass through a read of the column memory.
// The second digit of a pair draws a byte of up to eight pixels through a shift
// register, one pixel a cycle while no dot is written; each dot that is written stalls
// the shift for a read-modify-write of the column memory.
// Per-column valid bits make clear and reset immediate, so there is no clearing pass.
module dot_matrix_bitmap_blitter_unit import dmbb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // hex_char [7:0], column [14:8], row [19:15], pixel_color [20], zero fill
  input  logic [23:0]       s_tdata,
  // func [2:0]
  input  logic [2:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // column_bits [15:0], size_error [16], zero fill
  output logic [23:0]       m_tdata,
  input  logic              cfg_wr_en,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  state_t state, state_next;

  logic [6:0] x_off;
  logic [4:0] y_off;
  logic       color_cfg;
  logic [6:0] width_cfg;
  logic [4:0] height_cfg;

  logic [2:0] func_q;
  logic [7:0] hex_q;
  logic [6:0] col_q;
  logic [4:0] row_q;
  logic       pcol_q;

  logic [3:0]        high_nib;
  logic              phase;
  logic [CUR_XW-1:0] cur_x;
  logic [CUR_YW-1:0] cur_y;
  logic [CNT_W-1:0]  char_cnt;

  logic [SPAN_W-1:0] span_q;
  logic [DOT_XW-1:0] base_col;
  logic [DOT_YW-1:0] dot_row;
  logic [BYTE_W-1:0] byte_q;
  logic [COL_AW-1:0] addr_q;
  logic [ROW_IW-1:0] bit_q;
  logic              val_q;
  logic              rd_valid_q;

  logic [COLUMNS-1:0] valid;
  logic               fill;

  logic [OUT_BITS_W-1:0] res_bits;
  logic                  res_err;

  logic              rd_en;
  logic [COL_AW-1:0] rd_addr;
  logic [ROWS-1:0]   rd_data;
  logic              wr_en;
  logic [ROWS-1:0]   cur_word;
  logic [ROWS-1:0]   word_mod;

  shift_ctrl_t shift_ctrl;
  shift_stat_t shift_stat;

  logic              size_ok;
  logic              cnt_ok;
  logic              set_on;
  logic              read_on;
  logic [3:0]        nib;
  logic              x_wrap;
  logic [YC_W-1:0]   y_inc;
  logic [CUR_YW-1:0] y_adj;
  logic [CUR_XW-1:0] x_adj;
  logic [XC_W-1:0]   x_rem;
  logic [SPAN_W-1:0] span_calc;
  logic [XC_W-1:0]   x_sum;
  logic [YC_W-1:0]   y_next;
  logic [DOT_XW-1:0] pix_col;
  logic              pix_on;
  logic              accept;

  assign accept  = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);

  assign size_ok = (width_cfg != '0) && (XC_W'(width_cfg) <= XC_W'(COLUMNS)) &&
                   (height_cfg != '0) && (YC_W'(height_cfg) <= YC_W'(ROWS));
  assign cnt_ok  = char_cnt < CNT_W'(MAX_CHARS);
  assign set_on  = (XC_W'(col_q) < XC_W'(COLUMNS)) && (YC_W'(row_q) < YC_W'(ROWS));
  assign read_on = XC_W'(col_q) < XC_W'(COLUMNS);
  assign nib     = digit_value(hex_q);

  assign x_wrap = XC_W'(cur_x) >= XC_W'(width_cfg);
  assign y_inc  = x_wrap ? YC_W'(cur_y) + YC_W'(1) : YC_W'(cur_y);
  assign y_adj  = (y_inc >= YC_W'(height_cfg)) ? '0 : CUR_YW'(y_inc);
  assign x_adj  = x_wrap ? '0 : cur_x;

  assign x_rem     = XC_W'(width_cfg) - XC_W'(cur_x);
  assign span_calc = (x_rem > XC_W'(BYTE_W)) ? SPAN_W'(BYTE_W) : SPAN_W'(x_rem);
  assign x_sum     = XC_W'(cur_x) + XC_W'(span_q);
  assign y_next    = YC_W'(cur_y) + YC_W'(1);

  assign pix_col = base_col + DOT_XW'(shift_stat.offset);
  assign pix_on  = (pix_col < DOT_XW'(COLUMNS)) && (dot_row < DOT_YW'(ROWS));

  assign rd_addr  = (state == S_PIX) ? pix_col[COL_AW-1:0] : col_q[COL_AW-1:0];
  assign cur_word = rd_valid_q ? rd_data : {ROWS{fill}};

  always_comb begin
    word_mod        = cur_word;
    word_mod[bit_q] = val_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    shift_ctrl = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (func_q)
          FN_SET: begin
            if (set_on) begin
              rd_en      = 1'b1;
              state_next = S_WRITE;
            end
          end
          FN_HEX: begin
            if (size_ok && cnt_ok && phase) begin
              state_next = S_ALIGN;
            end
          end
          FN_READ: begin
            if (read_on) begin
              rd_en      = 1'b1;
              state_next = S_RD_OUT;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_RD_OUT: state_next = S_DONE;
      S_ALIGN: begin
        shift_ctrl.load = 1'b1;
        state_next      = S_PIX;
      end
      S_PIX: begin
        if (shift_stat.bit_out && pix_on) begin
          rd_en      = 1'b1;
          state_next = S_WRITE;
        end else if (shift_stat.last) begin
          state_next = S_ADV;
        end else begin
          shift_ctrl.step = 1'b1;
        end
      end
      S_WRITE: begin
        wr_en = 1'b1;
        if (func_q == FN_SET) begin
          state_next = S_DONE;
        end else if (shift_stat.last) begin
          state_next = S_ADV;
        end else begin
          shift_ctrl.step = 1'b1;
          state_next      = S_PIX;
        end
      end
      S_ADV: state_next = S_DONE;
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_off      <= '0;
      y_off      <= '0;
      color_cfg  <= 1'b1;
      width_cfg  <= 7'd8;
      height_cfg <= 5'd8;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_X_OFFSET: x_off      <= cfg_data[6:0];
        REG_Y_OFFSET: y_off      <= cfg_data[4:0];
        REG_COLOR:    color_cfg  <= cfg_data[0];
        REG_WIDTH:    width_cfg  <= cfg_data[6:0];
        REG_HEIGHT:   height_cfg <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= s_tuser;
      hex_q  <= s_tdata[7:0];
      col_q  <= s_tdata[14:8];
      row_q  <= s_tdata[19:15];
      pcol_q <= s_tdata[20];
    end
    if (rd_en) begin
      rd_valid_q <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_nib <= '0;
      phase    <= 1'b0;
      cur_x    <= '0;
      cur_y    <= '0;
      char_cnt <= '0;
      valid    <= '0;
      fill     <= 1'b0;
    end else begin
      case (state)
        S_EXEC: begin
          res_bits <= '0;
          res_err  <= (func_q == FN_HEX) && !size_ok;
          case (func_q)
            FN_CLEAR: begin
              valid <= '0;
              fill  <= pcol_q;
            end
            FN_SET: begin
              addr_q <= col_q[COL_AW-1:0];
              bit_q  <= row_q[ROW_IW-1:0];
              val_q  <= pcol_q;
            end
            FN_START: begin
              high_nib <= '0;
              phase    <= 1'b0;
              cur_x    <= '0;
              cur_y    <= '0;
              char_cnt <= '0;
            end
            FN_HEX: begin
              if (size_ok && cnt_ok) begin
                char_cnt <= char_cnt + 1'b1;
                if (!phase) begin
                  high_nib <= nib;
                  phase    <= 1'b1;
                end else begin
                  phase  <= 1'b0;
                  byte_q <= {high_nib, nib};
                  cur_x  <= x_adj;
                  cur_y  <= y_adj;
                end
              end
            end
            default: ;
          endcase
        end
        S_RD_OUT: res_bits <= OUT_BITS_W'(cur_word);
        S_ALIGN: begin
          span_q   <= span_calc;
          base_col <= DOT_XW'(x_off) + DOT_XW'(cur_x);
          dot_row  <= DOT_YW'(y_off) + DOT_YW'(cur_y);
        end
        S_PIX: begin
          addr_q <= pix_col[COL_AW-1:0];
          bit_q  <= dot_row[ROW_IW-1:0];
          val_q  <= color_cfg;
        end
        S_WRITE: valid[addr_q] <= 1'b1;
        S_ADV: begin
          if (x_sum >= XC_W'(width_cfg)) begin
            cur_x <= '0;
            cur_y <= (y_next >= YC_W'(height_cfg)) ? '0 : CUR_YW'(y_next);
          end else begin
            cur_x <= CUR_XW'(x_sum);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {7'd0, res_err, res_bits};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  dmbb_ram #(
    .WIDTH (ROWS),
    .DEPTH (COLUMNS)
  ) u_frame (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr_q),
    .wr_data (word_mod),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dmbb_shift u_shift (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (shift_ctrl),
    .pix_byte (byte_q),
    .span     (span_calc),
    .stat     (shift_stat)
  );

endmodule

// ----- sim/blitter_checker.sv -----
module blitter_checker
  import dmbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  // hex_char [7:0], column [14:8], row [19:15], pixel_color [20], zero fill
  input  logic [23:0]       s_tdata,
  // func [2:0]
  input  logic [2:0]        s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  // column_bits [15:0], size_error [16], zero fill
  input  logic [23:0]       m_tdata,
  input  logic              cfg_wr_en,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output int                fail_count,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUT_BITS_W-1:0] column_bits;
    logic                  size_error;
  } blit_result_t;

  blit_result_t    awaited_q[$];

  logic [ROWS-1:0] frame_model [COLUMNS];
  logic [3:0]      upper_digit;
  logic            second_digit;
  logic [6:0]      cur_x;
  logic [4:0]      cur_y;
  logic [7:0]      chars_seen;

  logic [6:0]      x_off;
  logic [4:0]      y_off;
  logic            ink;
  logic [6:0]      bmp_w;
  logic [4:0]      bmp_h;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
    return c[3:0];
  endfunction

  task automatic plot(input int col, input int r, input logic c);
    if (col < COLUMNS && r < ROWS) frame_model[col][r] = c;
  endtask

  task automatic draw_pair(input logic [7:0] pair_val);
    int x;
    int y;
    int span;
    x = cur_x;
    y = cur_y;
    if (x >= bmp_w) begin
      x = 0;
      y++;
    end
    if (y >= bmp_h) y = 0;
    span = bmp_w - x;
    if (span > 8) span = 8;
    for (int k = 0; k < span; k++) begin
      if (pair_val[k]) plot(x_off + x + (span - 1 - k), y_off + y, ink);
    end
    x += span;
    if (x >= bmp_w) begin
      x = 0;
      y++;
      if (y >= bmp_h) y = 0;
    end
    cur_x = 7'(x);
    cur_y = 5'(y);
  endtask

  task automatic predict(input logic [2:0] code, input logic [23:0] d,
                         output blit_result_t res);
    logic [7:0] ch;
    logic [6:0] col;
    logic [4:0] r;
    logic       c;
    logic [3:0] nib;
    res = '0;
    ch  = d[7:0];
    col = d[14:8];
    r   = d[19:15];
    c   = d[20];
    case (func_t'(code))
      FN_CLEAR: begin
        for (int i = 0; i < COLUMNS; i++) frame_model[i] = c ? '1 : '0;
      end
      FN_SET: plot(col, r, c);
      FN_START: begin
        cur_x        = '0;
        cur_y        = '0;
        second_digit = 1'b0;
        upper_digit  = '0;
        chars_seen   = '0;
      end
      FN_HEX: begin
        if (bmp_w < 1 || bmp_w > COLUMNS || bmp_h < 1 || bmp_h > ROWS) begin
          res.size_error = 1'b1;
        end else if (chars_seen < MAX_CHARS) begin
          chars_seen++;
          nib = nibble_of(ch);
          if (!second_digit) begin
            upper_digit  = nib;
            second_digit = 1'b1;
          end else begin
            second_digit = 1'b0;
            draw_pair({upper_digit, nib});
          end
        end
      end
      FN_READ: begin
        if (col < COLUMNS) res.column_bits = frame_model[col];
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    blit_result_t want;
    blit_result_t got;
    if (rst) begin
      awaited_q.delete();
      for (int i = 0; i < COLUMNS; i++) frame_model[i] = '0;
      upper_digit  = '0;
      second_digit = 1'b0;
      cur_x        = '0;
      cur_y        = '0;
      chars_seen   = '0;
      x_off        = '0;
      y_off        = '0;
      ink          = 1'b1;
      bmp_w        = 7'd8;
      bmp_h        = 5'd8;
      fail_count   = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.column_bits = m_tdata[OUT_BITS_W-1:0];
        got.size_error  = m_tdata[OUT_BITS_W];
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual column_bits %h size_error %b",
                   $time, got.column_bits, got.size_error);
          fail_count++;
        end else begin
          want = awaited_q.pop_front();
          if (got.column_bits !== want.column_bits) begin
            $display("%0t: column_bits mismatch, expected %h, actual %h",
                     $time, want.column_bits, got.column_bits);
            fail_count++;
          end
          if (got.size_error !== want.size_error) begin
            $display("%0t: size_error mismatch, expected %b, actual %b",
                     $time, want.size_error, got.size_error);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_X_OFFSET: x_off = cfg_data[6:0];
          REG_Y_OFFSET: y_off = cfg_data[4:0];
          REG_COLOR:    ink   = cfg_data[0];
          REG_WIDTH:    bmp_w = cfg_data[6:0];
          REG_HEIGHT:   bmp_h = cfg_data[4:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        predict(s_tuser, s_tdata, want);
        awaited_q.push_back(want);
      end
    end
    outstanding = awaited_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dmbb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 40;

  logic              clk;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic [23:0]       s_tdata   = '0;
  logic [2:0]        s_tuser   = '0;
  logic              m_tready  = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data  = '0;
  logic              s_tready;
  logic              m_tvalid;
  logic [23:0]       m_tdata;
  logic              calm      = 1'b0;
  int                cycles    = 0;
  int                fail_count;
  int                outstanding;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  dot_matrix_bitmap_blitter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  blitter_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    m_tready <= !rst && (calm || $urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(input func_t f, input logic [7:0] ch, input logic [6:0] col,
                           input logic [4:0] r, input logic c);
    if (!calm) begin
      while ($urandom_range(99) < 21) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {3'b000, c, r, col, ch};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic set_blit(input logic [6:0] x, input logic [4:0] y, input logic c,
                          input logic [6:0] w, input logic [4:0] h);
    write_reg(REG_X_OFFSET, x);
    write_reg(REG_Y_OFFSET, y);
    write_reg(REG_COLOR, c);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] hex_digit_char();
    int v;
    v = $urandom_range(21);
    if (v < 10) return 8'(8'h30 + v);
    if (v < 16) return 8'(8'h61 + v - 10);
    return 8'(8'h41 + v - 16);
  endfunction

  task automatic send_random(input int hex_pct, input int start_pct);
    int         pick;
    logic [7:0] ch;
    logic [6:0] col;
    logic [4:0] r;
    pick = $urandom_range(99);
    ch   = 8'($urandom_range(255));
    col  = 7'($urandom_range(127));
    r    = 5'($urandom_range(31));
    if (pick < hex_pct) begin
      if ($urandom_range(99) < 90) ch = hex_digit_char();
      send_item(FN_HEX, ch, col, r, 1'($urandom_range(1)));
    end else if (pick < hex_pct + start_pct) begin
      send_item(FN_START, ch, col, r, 1'($urandom_range(1)));
    end else if (pick < hex_pct + start_pct + 2) begin
      send_item(FN_CLEAR, ch, col, r, 1'($urandom_range(1)));
    end else if (pick < hex_pct + start_pct + 12) begin
      if ($urandom_range(3) != 0) begin
        col = 7'($urandom_range(79));
        r   = 5'($urandom_range(17));
      end
      send_item(FN_SET, ch, col, r, 1'($urandom_range(1)));
    end else if (pick < hex_pct + start_pct + 14) begin
      send_item(func_t'(3'($urandom_range(7, 5))), ch, col, r, 1'($urandom_range(1)));
    end else begin
      if ($urandom_range(7) != 0) col = 7'($urandom_range(COLUMNS - 1));
      send_item(FN_READ, ch, col, r, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_item(FN_READ, 8'h00, 7'd0, 5'd0, 1'b0);
    send_item(FN_READ, 8'h00, 7'd77, 5'd0, 1'b0);
    send_item(FN_READ, 8'h00, 7'd78, 5'd0, 1'b0);
    send_item(FN_SET, 8'h00, 7'd0, 5'd0, 1'b1);
    send_item(FN_SET, 8'h00, 7'd77, 5'd15, 1'b1);
    send_item(FN_SET, 8'h00, 7'd78, 5'd0, 1'b1);
    send_item(FN_SET, 8'h00, 7'd0, 5'd16, 1'b1);
    send_item(FN_READ, 8'h00, 7'd77, 5'd0, 1'b0);
    send_item(FN_CLEAR, 8'h00, 7'd0, 5'd0, 1'b1);
    send_item(FN_SET, 8'h00, 7'd40, 5'd7, 1'b0);
    send_item(FN_READ, 8'h00, 7'd40, 5'd0, 1'b0);
    send_item(FN_CLEAR, 8'h00, 7'd0, 5'd0, 1'b0);
    send_item(func_t'(3'd5), 8'hFF, 7'd127, 5'd31, 1'b1);
    send_item(func_t'(3'd7), 8'hFF, 7'd127, 5'd31, 1'b1);
    send_item(FN_START, 8'h00, 7'd0, 5'd0, 1'b0);
    send_item(FN_HEX, "8", 7'd0, 5'd0, 1'b0);
    send_item(FN_HEX, "1", 7'd0, 5'd0, 1'b0);
    send_item(FN_HEX, "F", 7'd0, 5'd0, 1'b0);
    send_item(FN_HEX, "a", 7'd0, 5'd0, 1'b0);
    send_item(FN_HEX, "A", 7'd0, 5'd0, 1'b0);
    send_item(FN_HEX, "9", 7'd0, 5'd0, 1'b0);
    send_item(FN_HEX, "g", 7'd0, 5'd0, 1'b0);
    send_item(FN_HEX, 8'hFF, 7'd0, 5'd0, 1'b0);
    send_item(FN_READ, 8'h00, 7'd0, 5'd0, 1'b0);
    send_item(FN_READ, 8'h00, 7'd7, 5'd0, 1'b0);

    for (int ph = 0; ph < 15; ph++) begin
      drain();
      case (ph)
        0:       set_blit(7'd0, 5'd0, 1'b1, 7'd78, 5'd16);
        1:       set_blit(7'd127, 5'd31, 1'b1, 7'd8, 5'd8);
        2:       set_blit(7'd70, 5'd12, 1'b0, 7'd13, 5'd7);
        3:       set_blit(7'd0, 5'd0, 1'b1, 7'd0, 5'd8);
        4:       set_blit(7'd3, 5'd2, 1'b1, 7'd1, 5'd1);
        7:       set_blit(7'd5, 5'd3, 1'b1, 7'd127, 5'd31);
        8:       set_blit(7'd20, 5'd4, 1'b1, 7'd30, 5'd0);
        9:       set_blit(7'd0, 5'd0, 1'b1, 7'd78, 5'd16);
        10:      set_blit(7'd10, 5'd0, 1'b1, 7'd20, 5'd17);
        11:      set_blit(7'd0, 5'd0, 1'b1, 7'd79, 5'd16);
        default: set_blit(($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                    : 7'($urandom_range(60)),
                          5'($urandom_range(15)), 1'($urandom_range(1)),
                          7'($urandom_range(78, 1)), 5'($urandom_range(16, 1)));
      endcase
      calm <= (ph == 5 || ph == 6);
      if (ph == 9) begin
        send_item(FN_START, 8'h00, 7'd0, 5'd0, 1'b0);
        repeat (206) begin
          send_item(FN_HEX, hex_digit_char(), 7'($urandom_range(127)),
                    5'($urandom_range(31)), 1'($urandom_range(1)));
        end
        repeat (16) begin
          send_item(FN_READ, 8'h00, 7'($urandom_range(COLUMNS - 1)), 5'd0, 1'b0);
        end
      end else begin
        repeat (95) send_random(50, (ph % 2 == 0) ? 6 : 1);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
